// ----- rtl/iqp_pkg.sv -----
`timescale 1ns / 1ps

package iqp_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int RATE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int ANG_FRAC       = 30;
  localparam int ROUND_SH       = ANG_FRAC - RATE_FRAC_BITS;

  // pi in Q30
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  // 2 * 1e6 us/s
  localparam logic [20:0] RATE_SCALE = 21'd2000000;

  // truncated atan(2^-i) in Q30
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd7,         30'd3,         30'd1,
    30'd0,         30'd0
  };

  typedef enum logic [1:0] {
    KIND_DROP   = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_ORIENT = 2'd2,
    KIND_RATE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_YAW_KNOWN   = 3'd0,
    REG_USE_ORIENT  = 3'd1,
    REG_USE_RATE    = 3'd2,
    REG_CORR_W      = 3'd3,
    REG_CORR_X      = 3'd4,
    REG_CORR_Y      = 3'd5,
    REG_CORR_Z      = 3'd6
  } reg_idx_t;

  // data that rides alongside the arithmetic, one copy per stage
  typedef struct packed {
    kind_t            kind;
    logic [31:0]      tstamp;
    logic [3:0][15:0] quat;     // w, x, y, z at 0..3
    logic             w_neg;
    logic [15:0]      w_abs;
    logic [2:0][15:0] mag;      // |x|, |y|, |z|
    logic [2:0]       v_neg;
    logic             no_rot;
    logic [15:0]      divisor;
  } side_t;

  typedef struct packed {
    logic [61:0] rem;
    logic [61:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [23:0]        nrm;
  } cordic_t;

  typedef struct packed {
    logic [2:0][23:0] rem;
    logic [2:0][31:0] quo;
    logic [23:0]      nrm;
  } div1_t;

  typedef struct packed {
    logic [2:0][15:0] rem;
    logic [2:0][52:0] quo;
  } div2_t;

endpackage

// ----- rtl/imu_quaternion_preprocess.sv -----
`timescale 1ns / 1ps

// IMU quaternion preprocessor. Orientation samples are passed raw until the
// yaw correction is known, then left-multiplied by the correction quaternion
// and rounded to Q2.14; delta quaternion samples become a Q16.16 rad/s rate
// 2*acos(w)*axis/dt with x negated and y/z swapped. Disabled kinds and
// deltas before the yaw is known are dropped. Every sample gives exactly
// one result beat. The rate path has a 31-stage square root (shared shape
// for sqrt(1-w^2) and the vector norm), 16 CORDIC vectoring stages, a
// 32-stage divide by the norm and a 53-stage divide by the interval, one
// bit per stage. One sample is accepted per clock, but the whole pipeline
// holds while a finished result waits on out_ready; configuration writes
// are taken at any time and must only be issued while the block is empty.
module imu_quaternion_preprocess
  import iqp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [31:0]        in_timestamp,
  input  logic signed [15:0] in_sample_w,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic signed [15:0] in_sample_z,
  input  logic [15:0]        in_interval_us,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [31:0]        out_time,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [31:0] out_rate_x,
  output logic signed [31:0] out_rate_y,
  output logic signed [31:0] out_rate_z
);

  localparam int SQ_N   = 31;
  localparam int D1_N   = 32;
  localparam int D2_N   = 53;
  localparam int ST_SQ  = 1;
  localparam int ST_CR  = ST_SQ + SQ_N + 1;
  localparam int ST_ANG = ST_CR + CORDIC_STEPS;
  localparam int ST_M1  = ST_ANG + 1;
  localparam int ST_D1  = ST_M1 + 1;
  localparam int ST_M2  = ST_D1 + D1_N;
  localparam int ST_D2  = ST_M2 + 1;
  localparam int LAST   = ST_D2 + D2_N - 1;

  localparam logic signed [15:0] ONE_Q    = 16'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [15:0] M_ONE_Q  = -ONE_Q;
  localparam logic [31:0]        ONE_SQ   = 32'd1 << (2 * QUAT_FRAC_BITS);
  localparam logic [53:0]        RND_HALF = 54'd1 << (ROUND_SH - 1);
  localparam logic [53:0]        POS_MAX  = 54'h7FFF_FFFF;
  localparam logic [53:0]        NEG_MAX  = 54'h8000_0000;

  // ---------------------------------------------------------------- config
  logic        yaw_known_r, use_orient_r, use_rate_r;
  logic [15:0] corr_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_known_r  <= 1'b0;
      use_orient_r <= 1'b1;
      use_rate_r   <= 1'b1;
      corr_r[0]    <= 16'd16384;
      corr_r[1]    <= 16'd0;
      corr_r[2]    <= 16'd0;
      corr_r[3]    <= 16'd0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_YAW_KNOWN:  yaw_known_r  <= cfg_data[0];
        REG_USE_ORIENT: use_orient_r <= cfg_data[0];
        REG_USE_RATE:   use_rate_r   <= cfg_data[0];
        REG_CORR_W:     corr_r[0]    <= cfg_data;
        REG_CORR_X:     corr_r[1]    <= cfg_data;
        REG_CORR_Y:     corr_r[2]    <= cfg_data;
        REG_CORR_Z:     corr_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- flow control
  logic            out_valid_r;
  logic            adv;
  logic [LAST:0]   vld_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // ------------------------------------------------------------ capture
  side_t              side0_nxt;
  logic signed [15:0] samp [4];
  logic signed [15:0] w_cl;
  logic signed [31:0] prod_nxt [4][4];
  logic signed [31:0] prod_r   [4][4];
  logic signed [31:0] wsq_r;
  logic signed [31:0] vsq_r [3];

  assign samp[0] = in_sample_w;
  assign samp[1] = in_sample_x;
  assign samp[2] = in_sample_y;
  assign samp[3] = in_sample_z;
  assign w_cl    = (in_sample_w < M_ONE_Q) ? M_ONE_Q : in_sample_w;

  always_comb begin
    side0_nxt        = '0;
    side0_nxt.tstamp = in_timestamp;
    if (!in_command) begin
      if (!yaw_known_r)      side0_nxt.kind = KIND_RAW;
      else if (use_orient_r) side0_nxt.kind = KIND_ORIENT;
      else                   side0_nxt.kind = KIND_DROP;
    end else begin
      side0_nxt.kind = (yaw_known_r && use_rate_r) ? KIND_RATE : KIND_DROP;
    end
    for (int k = 0; k < 4; k++) side0_nxt.quat[k] = samp[k];
    side0_nxt.w_neg = w_cl[15];
    side0_nxt.w_abs = w_cl[15] ? 16'(-w_cl) : w_cl;
    for (int k = 0; k < 3; k++) begin
      side0_nxt.v_neg[k] = samp[k+1][15];
      side0_nxt.mag[k]   = samp[k+1][15] ? 16'(-samp[k+1]) : samp[k+1];
    end
    side0_nxt.no_rot  = !(in_sample_w < ONE_Q) ||
                        (in_sample_x == 16'sd0 && in_sample_y == 16'sd0 &&
                         in_sample_z == 16'sd0);
    side0_nxt.divisor = (in_interval_us == 16'd0) ? 16'd1 : in_interval_us;
    for (int c = 0; c < 4; c++)
      for (int s = 0; s < 4; s++)
        prod_nxt[c][s] = $signed(corr_r[c]) * samp[s];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      wsq_r  <= w_cl * w_cl;
      for (int k = 0; k < 3; k++) vsq_r[k] <= samp[k+1] * samp[k+1];
    end
  end

  // --------------------------------------------- corrected orientation
  side_t              side_r [0:LAST];
  side_t              side1_nxt;
  logic signed [33:0] qsum [4];
  logic signed [33:0] qrnd [4];

  always_comb begin
    qsum[0] = 34'(prod_r[0][0]) - 34'(prod_r[1][1]) - 34'(prod_r[2][2]) - 34'(prod_r[3][3]);
    qsum[1] = 34'(prod_r[0][1]) + 34'(prod_r[1][0]) + 34'(prod_r[2][3]) - 34'(prod_r[3][2]);
    qsum[2] = 34'(prod_r[0][2]) - 34'(prod_r[1][3]) + 34'(prod_r[2][0]) + 34'(prod_r[3][1]);
    qsum[3] = 34'(prod_r[0][3]) + 34'(prod_r[1][2]) - 34'(prod_r[2][1]) + 34'(prod_r[3][0]);
    side1_nxt = side_r[0];
    for (int k = 0; k < 4; k++) begin
      // round half up, then clamp to 16 bits
      qrnd[k] = (qsum[k] + (34'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
      if (side_r[0].kind == KIND_ORIENT) begin
        if (qrnd[k] > 34'sd32767)       side1_nxt.quat[k] = 16'h7FFF;
        else if (qrnd[k] < -34'sd32768) side1_nxt.quat[k] = 16'h8000;
        else                            side1_nxt.quat[k] = qrnd[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0_nxt;
      side_r[1] <= side1_nxt;
      for (int k = 2; k <= LAST; k++) side_r[k] <= side_r[k-1];
    end
  end

  // ------------------------------------------------------- square roots
  sqrt_t       sqy_r [0:SQ_N];
  sqrt_t       sqn_r [0:SQ_N];
  logic [33:0] ss;
  logic [61:0] yrad, nrad;

  function automatic sqrt_t sqrt_step(sqrt_t s, logic [61:0] bitv);
    sqrt_t       o;
    logic [61:0] trial;
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  always_comb begin
    ss   = 34'(unsigned'(vsq_r[0])) + 34'(unsigned'(vsq_r[1])) + 34'(unsigned'(vsq_r[2]));
    yrad = (unsigned'(wsq_r) >= ONE_SQ) ? 62'd0
         : (62'(ONE_SQ - unsigned'(wsq_r)) << 32);
    nrad = 62'(ss) << 16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqy_r[0] <= '{rem: yrad, root: 62'd0};
      sqn_r[0] <= '{rem: nrad, root: 62'd0};
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (adv) begin
        sqy_r[j+1] <= sqrt_step(sqy_r[j], 62'd1 << (2 * (SQ_N - 1 - j)));
        sqn_r[j+1] <= sqrt_step(sqn_r[j], 62'd1 << (2 * (SQ_N - 1 - j)));
      end
    end
  end

  // ------------------------------------------------------------- CORDIC
  cordic_t cr_in [CORDIC_STEPS];
  cordic_t cr_r  [CORDIC_STEPS];

  function automatic cordic_t cordic_step(cordic_t c, int unsigned i);
    cordic_t            o;
    logic signed [33:0] dx, dy;
    logic signed [32:0] da;
    dx = c.y >>> i;
    dy = c.x >>> i;
    da = $signed({3'b000, ATAN_TAB[i]});
    o  = c;
    if (c.y > 34'sd0) begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + da;
    end else begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - da;
    end
    return o;
  endfunction

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    if (i == 0) begin : g_first
      always_comb begin
        cr_in[i].x   = $signed({2'b00, side_r[ST_CR-1].w_abs, 16'd0});
        cr_in[i].y   = $signed({2'b00, sqy_r[SQ_N].root[31:0]});
        cr_in[i].z   = '0;
        cr_in[i].nrm = sqn_r[SQ_N].root[23:0];
      end
    end else begin : g_next
      assign cr_in[i] = cr_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) cr_r[i] <= cordic_step(cr_in[i], i);
    end
  end

  // -------------------------------------------------------------- angle
  logic signed [34:0] ang_raw;
  logic [31:0]        ang_r;
  logic [23:0]        ang_nrm_r;

  assign ang_raw = side_r[ST_ANG-1].w_neg
                 ? $signed({3'b000, PI_Q30}) - 35'(cr_r[CORDIC_STEPS-1].z)
                 : 35'(cr_r[CORDIC_STEPS-1].z);

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_nrm_r <= cr_r[CORDIC_STEPS-1].nrm;
      if (ang_raw < 35'sd0)                          ang_r <= 32'd0;
      else if (ang_raw > $signed({3'b000, PI_Q30})) ang_r <= PI_Q30;
      else                                           ang_r <= ang_raw[31:0];
    end
  end

  // ------------------------------------------ angle * |v_i| * 256 / |v|
  logic [2:0][47:0] am;
  logic [2:0][55:0] m1_r;
  logic [23:0]      m1_nrm_r;
  div1_t            d1_in [D1_N];
  div1_t            d1_r  [D1_N];

  always_comb begin
    for (int k = 0; k < 3; k++) am[k] = ang_r * side_r[ST_M1-1].mag[k];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) m1_r[k] <= {am[k], 8'd0};
      m1_nrm_r <= ang_nrm_r;
    end
  end

  for (genvar j = 0; j < D1_N; j++) begin : g_div1
    div1_t       d1_nxt;
    logic [24:0] t1 [3];
    if (j == 0) begin : g_first
      always_comb begin
        d1_in[j].nrm = m1_nrm_r;
        for (int k = 0; k < 3; k++) begin
          d1_in[j].rem[k] = m1_r[k][55:32];
          d1_in[j].quo[k] = m1_r[k][31:0];
        end
      end
    end else begin : g_next
      assign d1_in[j] = d1_r[j-1];
    end
    always_comb begin
      d1_nxt = d1_in[j];
      for (int k = 0; k < 3; k++) begin
        t1[k] = {d1_in[j].rem[k], d1_in[j].quo[k][31]};
        if (t1[k] >= {1'b0, d1_in[j].nrm}) begin
          d1_nxt.rem[k] = 24'(t1[k] - {1'b0, d1_in[j].nrm});
          d1_nxt.quo[k] = {d1_in[j].quo[k][30:0], 1'b1};
        end else begin
          d1_nxt.rem[k] = t1[k][23:0];
          d1_nxt.quo[k] = {d1_in[j].quo[k][30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) d1_r[j] <= d1_nxt;
    end
  end

  // -------------------------------------------- * 2e6 / interval
  logic [2:0][52:0] m2_r;
  div2_t            d2_in [D2_N];
  div2_t            d2_r  [D2_N];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) m2_r[k] <= d1_r[D1_N-1].quo[k] * RATE_SCALE;
    end
  end

  for (genvar j = 0; j < D2_N; j++) begin : g_div2
    div2_t       d2_nxt;
    logic [16:0] t2 [3];
    logic [15:0] dv;
    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          d2_in[j].rem[k] = 16'd0;
          d2_in[j].quo[k] = m2_r[k];
        end
      end
    end else begin : g_next
      assign d2_in[j] = d2_r[j-1];
    end
    assign dv = side_r[ST_D2+j-1].divisor;
    always_comb begin
      d2_nxt = d2_in[j];
      for (int k = 0; k < 3; k++) begin
        t2[k] = {d2_in[j].rem[k], d2_in[j].quo[k][52]};
        if (t2[k] >= {1'b0, dv}) begin
          d2_nxt.rem[k] = 16'(t2[k] - {1'b0, dv});
          d2_nxt.quo[k] = {d2_in[j].quo[k][51:0], 1'b1};
        end else begin
          d2_nxt.rem[k] = t2[k][15:0];
          d2_nxt.quo[k] = {d2_in[j].quo[k][51:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) d2_r[j] <= d2_nxt;
    end
  end

  // ------------------------------------------------------------ output
  side_t              sd;
  logic [53:0]        rq [3];
  logic [31:0]        cap_pos [3];
  logic [31:0]        neg_val [3];
  logic signed [31:0] term_nxt [3];
  logic signed [31:0] rx_nxt, ry_nxt, rz_nxt;
  logic               rate_on, quat_on;

  logic [1:0]         kind_r;
  logic [31:0]        time_r;
  logic [3:0][15:0]   quat_r;
  logic signed [31:0] rx_r, ry_r, rz_r;

  assign sd      = side_r[LAST];
  assign rate_on = (sd.kind == KIND_RATE) && !sd.no_rot;
  assign quat_on = (sd.kind == KIND_RAW) || (sd.kind == KIND_ORIENT);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rq[k]      = ({1'b0, d2_r[D2_N-1].quo[k]} + RND_HALF) >> ROUND_SH;
      cap_pos[k] = (rq[k] > POS_MAX) ? 32'h7FFF_FFFF : rq[k][31:0];
      // magnitudes of 2^31 and above give the most negative value on negation
      neg_val[k] = (rq[k] > NEG_MAX) ? 32'h8000_0000 : 32'(-rq[k][31:0]);
      term_nxt[k] = sd.v_neg[k] ? $signed(neg_val[k]) : $signed(cap_pos[k]);
    end
    // x is negated after its own clamp, so it never reaches -2^31
    rx_nxt = sd.v_neg[0] ? $signed(cap_pos[0]) : -$signed(cap_pos[0]);
    ry_nxt = term_nxt[2];
    rz_nxt = term_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= sd.kind;
      time_r <= sd.tstamp;
      quat_r <= quat_on ? sd.quat : '0;
      rx_r   <= rate_on ? rx_nxt : 32'sd0;
      ry_r   <= rate_on ? ry_nxt : 32'sd0;
      rz_r   <= rate_on ? rz_nxt : 32'sd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_time        = time_r;
  assign out_w           = $signed(quat_r[0]);
  assign out_x           = $signed(quat_r[1]);
  assign out_y           = $signed(quat_r[2]);
  assign out_z           = $signed(quat_r[3]);
  assign out_rate_x      = rx_r;
  assign out_rate_y      = ry_r;
  assign out_rate_z      = rz_r;

  // ------------------------------------------------------------ checks
  a_drop_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_DROP |->
      out_w == 16'sd0 && out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0 &&
      out_rate_x == 32'sd0 && out_rate_y == 32'sd0 && out_rate_z == 32'sd0)
    else $error("dropped beat carries data");

  a_rate_no_quat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_RATE |->
      out_w == 16'sd0 && out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0)
    else $error("rate beat carries a quaternion");

  a_quat_no_rate : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_RAW || out_result_kind == KIND_ORIENT) |->
      out_rate_x == 32'sd0 && out_rate_y == 32'sd0 && out_rate_z == 32'sd0)
    else $error("orientation beat carries a rate");

  a_x_not_min : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rate_x != 32'sh8000_0000)
    else $error("negated x rate reached the negative limit");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv && vld_r[LAST] |=> vld_r[LAST])
    else $error("pipeline lost an item during a stall");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import iqp_pkg::*;

  localparam logic CMD_ORIENT = 1'b0;
  localparam logic CMD_DELTA  = 1'b1;

  typedef struct {
    kind_t       kind;
    logic [31:0] tstamp;
    logic [15:0] q [4];
    logic [31:0] r [3];
  } imu_result_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, in_command;
  logic [31:0] in_timestamp;
  logic signed [15:0] in_sample_w, in_sample_x, in_sample_y, in_sample_z;
  logic [15:0] in_interval_us;
  logic out_valid, out_ready;
  logic [1:0] out_result_kind;
  logic [31:0] out_time;
  logic signed [15:0] out_w, out_x, out_y, out_z;
  logic signed [31:0] out_rate_x, out_rate_y, out_rate_z;

  imu_quaternion_preprocess dut (.*);

  // shadow of the block's registers
  logic        sh_yaw_known, sh_use_orient, sh_use_rate;
  logic [15:0] sh_corr [4];

  imu_result_t pending_results [$];
  int  n_errors;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk)
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] quat_round(input longint signed s);
    longint signed v;
    v = (s + 8192) >>> QUAT_FRAC_BITS;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  // arccosine in Q30 via CORDIC vectoring of (|w|, sqrt(1-w^2))
  function automatic longint signed acos_angle(input longint signed w);
    longint signed wq, x, y, z, dx, dy, ang;
    longint unsigned wsq, one2;
    wq = w * (64'sd1 <<< (ANG_FRAC - QUAT_FRAC_BITS));
    one2 = 64'd1 << (2 * ANG_FRAC);
    x = wq < 0 ? -wq : wq;
    wsq = x * x;
    y = int_sqrt(wsq >= one2 ? 64'd0 : one2 - wsq);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    ang = wq < 0 ? longint'(PI_Q30) - z : z;
    if (ang < 0) ang = 0;
    if (ang > longint'(PI_Q30)) ang = PI_Q30;
    return ang;
  endfunction

  function automatic logic [31:0] axis_rate(input longint signed v, input longint unsigned ang,
                                            input longint unsigned nrm,
                                            input longint unsigned iv);
    longint unsigned mag, a, b, r;
    longint signed s;
    mag = v < 0 ? -v : v;
    a = (ang * mag * 256) / nrm;
    b = (a * 2000000) / iv;
    r = (b + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    if (r > (64'd1 << 32)) r = 64'd1 << 32;
    s = v < 0 ? -longint'(r) : longint'(r);
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    return s[31:0];
  endfunction

  function automatic imu_result_t predict_result(input logic cmd, input logic [31:0] ts,
                                                 input logic signed [15:0] pq [4],
                                                 input logic [15:0] iv);
    imu_result_t res;
    longint signed c [4], p [4], w, rx;
    longint unsigned ang, nrm, d;
    res.kind = KIND_DROP;
    res.tstamp = ts;
    for (int i = 0; i < 4; i++) begin
      res.q[i] = '0;
      c[i] = longint'($signed(sh_corr[i]));
      p[i] = longint'(pq[i]);
    end
    for (int i = 0; i < 3; i++) res.r[i] = '0;
    if (cmd == CMD_ORIENT) begin
      if (!sh_yaw_known) begin
        res.kind = KIND_RAW;
        for (int i = 0; i < 4; i++) res.q[i] = pq[i];
      end else if (sh_use_orient) begin
        res.kind = KIND_ORIENT;
        res.q[0] = quat_round(c[0]*p[0] - c[1]*p[1] - c[2]*p[2] - c[3]*p[3]);
        res.q[1] = quat_round(c[0]*p[1] + c[1]*p[0] + c[2]*p[3] - c[3]*p[2]);
        res.q[2] = quat_round(c[0]*p[2] - c[1]*p[3] + c[2]*p[0] + c[3]*p[1]);
        res.q[3] = quat_round(c[0]*p[3] + c[1]*p[2] - c[2]*p[1] + c[3]*p[0]);
      end
    end else if (sh_yaw_known && sh_use_rate) begin
      res.kind = KIND_RATE;
      if (p[0] < 16384 && (p[1] != 0 || p[2] != 0 || p[3] != 0)) begin
        w = p[0] < -16384 ? -16384 : p[0];
        ang = acos_angle(w);
        nrm = int_sqrt((p[1]*p[1] + p[2]*p[2] + p[3]*p[3]) << 16);
        d = iv == 0 ? 1 : iv;
        rx = -longint'($signed(axis_rate(p[1], ang, nrm, d)));
        if (rx > 64'sd2147483647) rx = 64'sd2147483647;
        res.r[0] = rx[31:0];
        res.r[1] = axis_rate(p[3], ang, nrm, d);
        res.r[2] = axis_rate(p[2], ang, nrm, d);
      end
    end
    return res;
  endfunction

  // result checker: handshake values are stable at the falling edge
  always @(negedge clk) begin
    imu_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", out_time, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_result_kind !== e.kind) report("kind", out_result_kind, e.kind);
        if (out_time !== e.tstamp) report("time", out_time, e.tstamp);
        if (out_w !== e.q[0]) report("w", out_w, e.q[0]);
        if (out_x !== e.q[1]) report("x", out_x, e.q[1]);
        if (out_y !== e.q[2]) report("y", out_y, e.q[2]);
        if (out_z !== e.q[3]) report("z", out_z, e.q[3]);
        if (out_rate_x !== e.r[0]) report("rate_x", out_rate_x, e.r[0]);
        if (out_rate_y !== e.r[1]) report("rate_y", out_rate_y, e.r[1]);
        if (out_rate_z !== e.r[2]) report("rate_z", out_rate_z, e.r[2]);
      end
    end
  end

  // called at a rising edge, returns at the rising edge where the beat was taken
  task automatic send_sample(input logic cmd, input logic [31:0] ts,
                             input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z,
                             input logic [15:0] iv);
    logic signed [15:0] pq [4];
    if (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_timestamp <= ts;
    in_sample_w <= w;
    in_sample_x <= x;
    in_sample_y <= y;
    in_sample_z <= z;
    in_interval_us <= iv;
    pq = '{w, x, y, z};
    do @(negedge clk); while (!in_ready);
    pending_results.push_back(predict_result(cmd, ts, pq, iv));
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    case (idx)
      REG_YAW_KNOWN:  sh_yaw_known = val[0];
      REG_USE_ORIENT: sh_use_orient = val[0];
      REG_USE_RATE:   sh_use_rate = val[0];
      REG_CORR_W:     sh_corr[0] = val;
      REG_CORR_X:     sh_corr[1] = val;
      REG_CORR_Y:     sh_corr[2] = val;
      REG_CORR_Z:     sh_corr[3] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic yaw, input logic orient, input logic rate);
    write_reg(REG_YAW_KNOWN, {15'd0, yaw});
    write_reg(REG_USE_ORIENT, {15'd0, orient});
    write_reg(REG_USE_RATE, {15'd0, rate});
  endtask

  task automatic set_corr(input logic [15:0] w, input logic [15:0] x,
                          input logic [15:0] y, input logic [15:0] z);
    write_reg(REG_CORR_W, w);
    write_reg(REG_CORR_X, x);
    write_reg(REG_CORR_Y, y);
    write_reg(REG_CORR_Z, z);
  endtask

  function automatic logic signed [15:0] rand_part;
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);     // full 16-bit pattern, beyond the usual range
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic logic [15:0] rand_interval;
    case ($urandom_range(7))
      0: return 16'($urandom_range(8));
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // uncalibrated: orientations pass raw, deltas are dropped
  task automatic test_uncalibrated;
    send_sample(CMD_ORIENT, 32'h0, 16'sd16384, -16'sd16384, 16'sd0, 16'sd1, 16'd1);
    send_sample(CMD_ORIENT, 32'hFFFF_FFFF, -16'sd16384, 16'sd16384, -16'sd1, 16'sd0, 16'hFFFF);
    send_sample(CMD_ORIENT, 32'h5555_AAAA, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA, 16'd0);
    send_sample(CMD_DELTA, 32'h1234_5678, 16'sd8000, 16'sd3000, 16'sd100, -16'sd200, 16'd1000);
    drain();
  endtask

  task automatic test_orientation;
    set_mode(1'b1, 1'b1, 1'b1);
    set_corr(16'd11585, 16'd0, 16'd0, 16'd11585);
    send_sample(CMD_ORIENT, 32'd10, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd1);
    send_sample(CMD_ORIENT, 32'd11, 16'sd11585, 16'sd5000, -16'sd7000, 16'sd9000, 16'd1);
    drain();
    // extreme corrections drive the product sums into saturation
    set_corr(16'd16384, -16'sd16384, 16'd16384, -16'sd16384);
    send_sample(CMD_ORIENT, 32'd12, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 16'd1);
    send_sample(CMD_ORIENT, 32'd13, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 16'd1);
    send_sample(CMD_ORIENT, 32'd14, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'd1);
    drain();
    set_mode(1'b1, 1'b0, 1'b1);
    send_sample(CMD_ORIENT, 32'd15, 16'sd9000, 16'sd1000, 16'sd2000, 16'sd3000, 16'd1);
    drain();
  endtask

  task automatic test_rates;
    set_mode(1'b1, 1'b1, 1'b1);
    set_corr(16'd16384, 16'd0, 16'd0, 16'd0);
    send_sample(CMD_DELTA, 32'd20, 16'sd16384, 16'sd100, 16'sd0, 16'sd0, 16'd100);
    send_sample(CMD_DELTA, 32'd21, 16'sd16000, 16'sd0, 16'sd0, 16'sd0, 16'd100);
    send_sample(CMD_DELTA, 32'd22, -16'sd20000, 16'sd1, -16'sd1, 16'sd1, 16'd1);
    send_sample(CMD_DELTA, 32'd23, -16'sd32768, 16'sd16384, 16'sd0, 16'sd0, 16'd0);
    send_sample(CMD_DELTA, 32'd24, 16'sd0, -16'sd16384, 16'sd16384, -16'sd16384, 16'hFFFF);
    send_sample(CMD_DELTA, 32'd25, 16'sd16383, 16'sd0, 16'sd0, -16'sd1, 16'd1);
    send_sample(CMD_DELTA, 32'd26, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'd1000);
    drain();
    set_mode(1'b1, 1'b1, 1'b0);
    send_sample(CMD_DELTA, 32'd27, 16'sd0, 16'sd100, 16'sd100, 16'sd100, 16'd10);
    drain();
  endtask

  task automatic test_random(input int n_phases, input int per_phase);
    for (int ph = 0; ph < n_phases; ph++) begin
      set_mode($urandom_range(99) < 85, $urandom_range(99) < 80, $urandom_range(99) < 80);
      set_corr(rand_part(), rand_part(), rand_part(), rand_part());
      no_idle = (ph == 1);
      for (int i = 0; i < per_phase; i++) begin
        send_sample(1'($urandom_range(1)), $urandom, rand_part(), rand_part(), rand_part(),
                    rand_part(), rand_interval());
        if (ph == 3 && i == per_phase / 2) drain();
      end
      drain();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    n_errors = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_command = 1'b0; in_timestamp = '0;
    in_sample_w = '0; in_sample_x = '0; in_sample_y = '0; in_sample_z = '0;
    in_interval_us = '0;
    sh_yaw_known = 1'b0; sh_use_orient = 1'b1; sh_use_rate = 1'b1;
    sh_corr = '{16'd16384, 16'd0, 16'd0, 16'd0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_uncalibrated();
    test_orientation();
    test_rates();
    test_random(10, 133);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
